>>> rtl/tqc_pkg.sv
// Package for the two-queue cache replacement block: sizes, queue codes, outcome codes
// and the per-access plan type. Used by two_queue_cache_policy; tqc_ram does not import it.
`timescale 1ns / 1ps
package tqc_pkg;

  localparam int Capacity = 64;
  localparam int KeyBits  = 32;
  localparam int AddrW    = $clog2(Capacity);
  localparam int AgeW     = AddrW;
  localparam int CntW     = AddrW + 1;
  localparam int CfgW     = 7;
  localparam int EffW     = (CntW > CfgW) ? CntW : CfgW;
  localparam int MetaW    = AgeW + 2;

  localparam logic [CfgW-1:0] CacheSizeReset = CfgW'(64);

  typedef enum logic [1:0] {
    QEmpty = 2'd0,
    QMain  = 2'd1,
    QEntry = 2'd2,
    QGhost = 2'd3
  } queue_e;

  localparam logic [1:0] OutNew   = 2'd0;
  localparam logic [1:0] OutGhost = 2'd1;
  localparam logic [1:0] OutEntry = 2'd2;
  localparam logic [1:0] OutMain  = 2'd3;

  // What the write-back sweep does to each slot for one access.
  typedef struct packed {
    logic [1:0]      kind;
    logic [AddrW-1:0] s_idx;
    logic [AgeW-1:0] s_age;
    queue_e          s_q;
    logic            ev_a_v;
    logic [AddrW-1:0] ev_a_idx;
    logic            ev_b_v;
    logic [AddrW-1:0] ev_b_idx;
    logic            b_to_ghost;
    logic            new_v;
    logic [AddrW-1:0] new_idx;
    queue_e          ins_q;
    logic            bump_ghost;
    logic            m_pos;
  } plan_t;

endpackage

>>> rtl/two_queue_cache_policy.sv
// Top level of the 2Q cache replacement block: control sequencer around a key RAM and
// a queue/age RAM. Depends on tqc_pkg and tqc_ram.
//
// Usage: raise start with a page key while busy is low; the transaction is taken on that
// edge and busy rises. The block then scans all Capacity slots through the memories to
// find the key, the queue fill levels, the oldest slot of each queue and the first free
// slot, settles the plan in the SDecide state, and sweeps all slots again to rewrite
// queue and age, and the key of an inserted page. done_o is high for exactly one cycle
// with hit_o, outcome_o and hit_total_o; busy is already low in that cycle. A new access
// is taken only after both passes over the single read port of each memory are through.
// The result cannot be stalled: it is shown once and must be sampled then.
// After reset, and after every write of cache_size, a clearing pass empties the queue memory
// and the hit count is zeroed; busy is high meanwhile. cache_size is written through
// cfg_we_i / cfg_data_i, by the user only while the block is idle; the block does not enforce it.
module two_queue_cache_policy (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [31:0]             page_key_i,
  input  logic                    cfg_we_i,
  input  logic [tqc_pkg::CfgW-1:0] cfg_data_i,
  output logic                    done_o,
  output logic                    hit_o,
  output logic [1:0]              outcome_o,
  output logic [31:0]             hit_total_o
);
  import tqc_pkg::*;

  typedef enum logic [4:0] {
    SClear  = 5'b00001,
    SIdle   = 5'b00010,
    SScan   = 5'b00100,
    SDecide = 5'b01000,
    SUpdate = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             rd_v_q;
  logic [AddrW-1:0] rd_idx_q;
  logic [CfgW-1:0]  cache_size_q;
  logic [KeyBits-1:0] key_q;
  logic [31:0]      hit_cnt_q;
  logic             hit_q, done_q;
  logic [1:0]       outcome_q;
  plan_t            plan_q;

  // Scan results.
  logic             match_v_q;
  logic [AddrW-1:0] match_idx_q;
  queue_e           match_q_q;
  logic [AgeW-1:0]  match_age_q;
  logic [CntW-1:0]  cnt_main_q, cnt_entry_q, cnt_ghost_q;
  logic             om_v_q, oe_v_q, og_v_q, fe_v_q;
  logic [AddrW-1:0] om_idx_q, oe_idx_q, og_idx_q, fe_idx_q;
  logic [AgeW-1:0]  om_age_q, oe_age_q, og_age_q;

  logic             issue;
  logic [AddrW-1:0] raddr;
  logic [KeyBits-1:0] key_rd;
  logic [MetaW-1:0] meta_rd, meta_wd;
  logic             meta_we, key_we;
  logic [AddrW-1:0] meta_wa;
  queue_e           rq;
  logic [AgeW-1:0]  ra;
  logic             accept;

  assign accept = start && !busy;
  assign issue  = (cnt_q < CntW'(Capacity));
  assign raddr  = cnt_q[AddrW-1:0];
  assign rq     = queue_e'(meta_rd[MetaW-1:AgeW]);
  assign ra     = meta_rd[AgeW-1:0];

  tqc_ram #(.Width(KeyBits), .Depth(Capacity)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (rd_idx_q),
    .wdata_i (key_q),
    .raddr_i (raddr),
    .rdata_o (key_rd)
  );

  tqc_ram #(.Width(MetaW), .Depth(Capacity)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_wa),
    .wdata_i (meta_wd),
    .raddr_i (raddr),
    .rdata_o (meta_rd)
  );

  // Per-slot rewrite during the update sweep.
  queue_e          nq;
  logic [AgeW-1:0] na;
  always_comb begin
    nq = rq;
    na = ra;
    case (plan_q.kind)
      OutMain, OutEntry: begin
        if (rd_idx_q == plan_q.s_idx) begin
          nq = plan_q.s_q;
          na = '0;
        end else if (rq == plan_q.s_q && ra < plan_q.s_age) begin
          na = ra + AgeW'(1);
        end
      end
      OutGhost: begin
        if (rd_idx_q == plan_q.s_idx) begin
          nq = plan_q.m_pos ? QMain : QEmpty;
          na = '0;
        end else if (plan_q.ev_a_v && rd_idx_q == plan_q.ev_a_idx) begin
          nq = QEmpty;
          na = '0;
        end else if (rq == QGhost && ra > plan_q.s_age) begin
          na = ra - AgeW'(1);
        end else if (rq == QMain && plan_q.m_pos) begin
          na = ra + AgeW'(1);
        end
      end
      default: begin
        if (plan_q.new_v && rd_idx_q == plan_q.new_idx) begin
          nq = plan_q.ins_q;
          na = '0;
        end else if (plan_q.ev_a_v && rd_idx_q == plan_q.ev_a_idx) begin
          nq = QEmpty;
          na = '0;
        end else if (plan_q.ev_b_v && rd_idx_q == plan_q.ev_b_idx) begin
          nq = plan_q.b_to_ghost ? QGhost : QEmpty;
          na = '0;
        end else if (plan_q.bump_ghost && rq == QGhost) begin
          na = ra + AgeW'(1);
        end else if (plan_q.new_v && rq == plan_q.ins_q) begin
          na = ra + AgeW'(1);
        end
      end
    endcase
  end

  always_comb begin
    meta_we = 1'b0;
    meta_wa = rd_idx_q;
    meta_wd = {nq, na};
    key_we  = 1'b0;
    if (state_q == SClear) begin
      meta_we = issue;
      meta_wa = raddr;
      meta_wd = {QEmpty, AgeW'(0)};
    end else if (state_q == SUpdate) begin
      meta_we = rd_v_q;
      key_we  = rd_v_q && plan_q.new_v && plan_q.kind == OutNew
                && rd_idx_q == plan_q.new_idx;
    end
  end

  // Queue split and the plan for this access.
  logic [EffW-1:0] eff, m_sz, e_sz, g_sz;
  logic            lru;
  plan_t           plan_d;
  logic            do_e, ev_g, mv_e, ev_m;
  logic            hit_d;
  logic [1:0]      outcome_d;
  always_comb begin
    eff  = (EffW'(cache_size_q) > EffW'(Capacity)) ? EffW'(Capacity) : EffW'(cache_size_q);
    lru  = (eff <= EffW'(3));
    m_sz = lru ? eff : (eff >> 1);
    e_sz = lru ? '0 : ((eff - m_sz) >> 1);
    g_sz = eff - m_sz - e_sz;
    ev_m = (EffW'(cnt_main_q) >= m_sz) && om_v_q;
    do_e = (EffW'(cnt_entry_q) >= e_sz);
    ev_g = do_e && (EffW'(cnt_ghost_q) >= g_sz) && og_v_q;
    mv_e = do_e && oe_v_q;

    plan_d            = '0;
    plan_d.s_idx      = match_idx_q;
    plan_d.s_age      = match_age_q;
    plan_d.s_q        = match_q_q;
    plan_d.m_pos      = (m_sz != '0);
    plan_d.ins_q      = QMain;
    hit_d             = 1'b0;
    if (match_v_q && match_q_q == QMain) begin
      plan_d.kind = OutMain;
      hit_d       = 1'b1;
    end else if (match_v_q && match_q_q == QEntry) begin
      plan_d.kind = OutEntry;
      hit_d       = 1'b1;
    end else if (match_v_q) begin
      plan_d.kind     = OutGhost;
      plan_d.ev_a_v   = ev_m;
      plan_d.ev_a_idx = om_idx_q;
    end else if (lru) begin
      plan_d.kind     = OutNew;
      plan_d.ev_a_v   = ev_m && plan_d.m_pos;
      plan_d.ev_a_idx = om_idx_q;
      plan_d.new_v    = plan_d.m_pos && (fe_v_q || plan_d.ev_a_v);
      plan_d.new_idx  = fe_v_q ? fe_idx_q : om_idx_q;
      if (plan_d.ev_a_v && fe_v_q && om_idx_q < fe_idx_q) begin
        plan_d.new_idx = om_idx_q;
      end
    end else begin
      plan_d.kind       = OutNew;
      plan_d.ins_q      = QEntry;
      plan_d.ev_a_v     = ev_g;
      plan_d.ev_a_idx   = og_idx_q;
      plan_d.ev_b_v     = mv_e;
      plan_d.ev_b_idx   = oe_idx_q;
      plan_d.b_to_ghost = (g_sz != '0);
      plan_d.bump_ghost = mv_e && (g_sz != '0);
      // First free slot after the evictions: the lowest of all candidates.
      plan_d.new_v      = fe_v_q;
      plan_d.new_idx    = fe_idx_q;
      if (ev_g && (!plan_d.new_v || og_idx_q < plan_d.new_idx)) begin
        plan_d.new_v   = 1'b1;
        plan_d.new_idx = og_idx_q;
      end
      if (mv_e && g_sz == '0 && (!plan_d.new_v || oe_idx_q < plan_d.new_idx)) begin
        plan_d.new_v   = 1'b1;
        plan_d.new_idx = oe_idx_q;
      end
      plan_d.new_v = plan_d.new_v && (e_sz != '0);
    end
    outcome_d = plan_d.kind;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      SClear: begin
        cnt_d = cnt_q + CntW'(1);
        if (!issue) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        cnt_d = '0;
        if (accept) begin
          state_d = SScan;
        end
      end
      SScan: begin
        if (issue) begin
          cnt_d = cnt_q + CntW'(1);
        end
        if (rd_v_q && rd_idx_q == AddrW'(Capacity - 1)) begin
          state_d = SDecide;
          cnt_d   = '0;
        end
      end
      SDecide: begin
        state_d = SUpdate;
      end
      SUpdate: begin
        if (issue) begin
          cnt_d = cnt_q + CntW'(1);
        end
        if (rd_v_q && rd_idx_q == AddrW'(Capacity - 1)) begin
          state_d = SIdle;
        end
      end
      default: state_d = SClear;
    endcase
    if (cfg_we_i) begin
      state_d = SClear;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SClear;
      cnt_q        <= '0;
      rd_v_q       <= 1'b0;
      cache_size_q <= CacheSizeReset;
      hit_cnt_q    <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rd_v_q  <= issue && (state_q == SScan || state_q == SUpdate) && !cfg_we_i;
      done_q  <= (state_q == SUpdate) && rd_v_q && rd_idx_q == AddrW'(Capacity - 1);
      if (cfg_we_i) begin
        cache_size_q <= cfg_data_i;
        hit_cnt_q    <= '0;
      end else if (state_q == SDecide && hit_d && hit_cnt_q != '1) begin
        hit_cnt_q <= hit_cnt_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= raddr;
    if (accept) begin
      key_q       <= KeyBits'(page_key_i);
      match_v_q   <= 1'b0;
      om_v_q      <= 1'b0;
      oe_v_q      <= 1'b0;
      og_v_q      <= 1'b0;
      fe_v_q      <= 1'b0;
      cnt_main_q  <= '0;
      cnt_entry_q <= '0;
      cnt_ghost_q <= '0;
    end else if (state_q == SScan && rd_v_q) begin
      if (rq != QEmpty && key_rd == key_q) begin
        match_v_q   <= 1'b1;
        match_idx_q <= rd_idx_q;
        match_q_q   <= rq;
        match_age_q <= ra;
      end
      if (rq == QEmpty && !fe_v_q) begin
        fe_v_q   <= 1'b1;
        fe_idx_q <= rd_idx_q;
      end
      if (rq == QMain) begin
        cnt_main_q <= cnt_main_q + CntW'(1);
        if (!om_v_q || ra > om_age_q) begin
          om_v_q   <= 1'b1;
          om_idx_q <= rd_idx_q;
          om_age_q <= ra;
        end
      end
      if (rq == QEntry) begin
        cnt_entry_q <= cnt_entry_q + CntW'(1);
        if (!oe_v_q || ra > oe_age_q) begin
          oe_v_q   <= 1'b1;
          oe_idx_q <= rd_idx_q;
          oe_age_q <= ra;
        end
      end
      if (rq == QGhost) begin
        cnt_ghost_q <= cnt_ghost_q + CntW'(1);
        if (!og_v_q || ra > og_age_q) begin
          og_v_q   <= 1'b1;
          og_idx_q <= rd_idx_q;
          og_age_q <= ra;
        end
      end
    end
    if (state_q == SDecide) begin
      plan_q    <= plan_d;
      hit_q     <= hit_d;
      outcome_q <= outcome_d;
    end
  end

  assign busy        = (state_q != SIdle);
  assign done_o      = done_q;
  assign hit_o       = hit_q;
  assign outcome_o   = outcome_q;
  assign hit_total_o = hit_cnt_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register is not one-hot");

  a_hit_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hit_o == outcome_o[1])) else $error("hit flag disagrees with outcome");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held for more than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !$past(cfg_we_i) |-> state_q == SIdle) else $error("result without return to idle");

endmodule

>>> rtl/tqc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tqc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
